// ===== design/olte_pkg.sv =====
// Package for the ordered list table engine: payload structs, operation and
// status codes, cell command type and sizing constants.
// No dependencies.
package olte_pkg;

   localparam int DATA_W           = 32;
   localparam int POS_W            = 7;
   localparam int DEFAULT_CAPACITY = 64;

   typedef enum logic [2:0] {
      KIND_CLEAR      = 3'd0,
      KIND_INSERT     = 3'd1,
      KIND_APPEND     = 3'd2,
      KIND_DELETE     = 3'd3,
      KIND_DELETE_ALL = 3'd4,
      KIND_FIND       = 3'd5,
      KIND_READ       = 3'd6
   } olte_kind_type;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_OVERFLOW = 2'd1,
      STATUS_BAD_POS  = 2'd2
   } olte_status_type;

   typedef struct packed {
      olte_kind_type              kind;
      logic [POS_W-1:0]           position;
      logic signed [DATA_W-1:0]   entry_value;
   } olte_req_type;

   typedef struct packed {
      olte_status_type            status;
      logic [POS_W-1:0]           found_position;
      logic signed [DATA_W-1:0]   read_value;
      logic [POS_W-1:0]           list_length;
   } olte_rsp_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_SHIFT_UP,
      CELL_SHIFT_DOWN,
      CELL_ROTATE
   } olte_cell_op_type;

   typedef struct packed {
      olte_cell_op_type op;
      logic             write_en;
   } olte_cell_cmd_type;

   typedef enum logic {
      ST_IDLE,
      ST_SCAN
   } olte_state_type;

endpackage

// ===== design/olte_cell.sv =====
// One list entry of the cell chain; takes data from its left or right
// neighbor or from the broadcast value. Depends on olte_pkg.
module olte_cell
   import olte_pkg::*;
#(
   parameter int LW  = 7,
   parameter int IDX = 0
) (
   input  logic                clock,
   input  olte_cell_cmd_type   cmd,
   input  logic [LW-1:0]       index,
   input  logic [DATA_W-1:0]   wr_value,
   input  logic [DATA_W-1:0]   left_value,
   input  logic [DATA_W-1:0]   right_value,
   output logic [DATA_W-1:0]   value
);

   localparam logic [LW-1:0] MY_IDX = LW'(IDX);

   logic [DATA_W-1:0] entry_ff, entry_in;

   always_comb begin
      entry_in = entry_ff;
      case (cmd.op)
         CELL_SHIFT_UP: begin
            if (MY_IDX > index) begin
               entry_in = left_value;
            end else if (MY_IDX == index) begin
               entry_in = wr_value;
            end
         end
         CELL_SHIFT_DOWN: begin
            if (MY_IDX >= index) begin
               entry_in = right_value;
            end
         end
         CELL_ROTATE: begin
            // head leaves, kept head re-enters at the tail of the live list
            if (cmd.write_en && MY_IDX == index) begin
               entry_in = wr_value;
            end else begin
               entry_in = right_value;
            end
         end
         default: entry_in = entry_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign value = entry_ff;

endmodule

// ===== design/olte_ctrl.sv =====
// Sequencer of the list engine: checks operations, drives the cell chain,
// runs the head scan for find, read and delete-all. Depends on olte_pkg.
module olte_ctrl
   import olte_pkg::*;
#(
   parameter int CAPACITY = DEFAULT_CAPACITY,
   parameter int LW       = 7
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  olte_req_type        req,
   output logic                rsp_valid,
   output olte_rsp_type        rsp,
   input  logic [DATA_W-1:0]   head_value,
   output olte_cell_cmd_type   cell_cmd,
   output logic [LW-1:0]       cell_index,
   output logic [DATA_W-1:0]   cell_value
);

   localparam logic [LW-1:0] CAP_L = LW'(CAPACITY);

   olte_state_type     state_ff, state_in;
   logic [LW-1:0]      count_ff, count_in;
   logic [LW-1:0]      step_ff, step_in;
   logic [LW-1:0]      last_ff, last_in;
   logic [LW-1:0]      tgt_ff, tgt_in;
   logic [LW-1:0]      found_ff, found_in;
   olte_kind_type      mode_ff, mode_in;
   logic [DATA_W-1:0]  val_ff, val_in;
   logic [DATA_W-1:0]  rd_ff, rd_in;
   olte_rsp_type       rsp_ff, rsp_in;
   logic               rsp_valid_ff, rsp_valid_in;

   logic [LW-1:0]      pos_ext;
   logic               full;
   logic               keep;

   assign pos_ext = LW'(req.position);
   assign full    = (count_ff >= CAP_L);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      step_in      = step_ff;
      last_in      = last_ff;
      tgt_in       = tgt_ff;
      found_in     = found_ff;
      mode_in      = mode_ff;
      val_in       = val_ff;
      rd_in        = rd_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = 1'b0;
      cell_cmd     = '{op: CELL_HOLD, write_en: 1'b0};
      cell_index   = '0;
      cell_value   = req.entry_value;
      keep         = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               rsp_valid_in          = 1'b1;
               rsp_in.status         = STATUS_OK;
               rsp_in.found_position = '0;
               rsp_in.read_value     = '0;
               case (req.kind)
                  KIND_CLEAR: count_in = '0;
                  KIND_INSERT: begin
                     if (full) begin
                        rsp_in.status = STATUS_OVERFLOW;
                     end else if (pos_ext == '0 || pos_ext > count_ff + LW'(1)) begin
                        rsp_in.status = STATUS_BAD_POS;
                     end else begin
                        cell_cmd.op = CELL_SHIFT_UP;
                        cell_index  = pos_ext - LW'(1);
                        count_in    = count_ff + LW'(1);
                     end
                  end
                  KIND_APPEND: begin
                     if (full) begin
                        rsp_in.status = STATUS_OVERFLOW;
                     end else begin
                        cell_cmd.op = CELL_SHIFT_UP;
                        cell_index  = count_ff;
                        count_in    = count_ff + LW'(1);
                     end
                  end
                  KIND_DELETE: begin
                     if (pos_ext == '0 || pos_ext > count_ff) begin
                        rsp_in.status = STATUS_BAD_POS;
                     end else begin
                        cell_cmd.op = CELL_SHIFT_DOWN;
                        cell_index  = pos_ext - LW'(1);
                        count_in    = count_ff - LW'(1);
                     end
                  end
                  KIND_DELETE_ALL, KIND_FIND, KIND_READ: begin
                     if (req.kind == KIND_READ &&
                         (pos_ext == '0 || pos_ext > count_ff)) begin
                        rsp_in.status = STATUS_BAD_POS;
                     end else if (count_ff != '0) begin
                        rsp_valid_in = 1'b0;
                        state_in     = ST_SCAN;
                        mode_in      = req.kind;
                        val_in       = req.entry_value;
                        tgt_in       = pos_ext - LW'(1);
                        step_in      = '0;
                        last_in      = count_ff - LW'(1);
                        found_in     = '0;
                        rd_in        = '0;
                     end
                  end
                  default: ;
               endcase
               rsp_in.list_length = count_in[POS_W-1:0];
            end
         end
         ST_SCAN: begin
            // one entry per cycle passes the head; the list is back in order
            // after the last step
            keep       = !(mode_ff == KIND_DELETE_ALL && head_value == val_ff);
            cell_cmd   = '{op: CELL_ROTATE, write_en: keep};
            cell_index = count_ff - LW'(1);
            cell_value = head_value;
            if (!keep) begin
               count_in = count_ff - LW'(1);
            end
            if (mode_ff == KIND_FIND && head_value == val_ff && found_ff == '0) begin
               found_in = step_ff + LW'(1);
            end
            if (mode_ff == KIND_READ && step_ff == tgt_ff) begin
               rd_in = head_value;
            end
            step_in = step_ff + LW'(1);
            if (step_ff == last_ff) begin
               state_in              = ST_IDLE;
               rsp_valid_in          = 1'b1;
               rsp_in.status         = STATUS_OK;
               rsp_in.found_position = found_in[POS_W-1:0];
               rsp_in.read_value     = rd_in;
               rsp_in.list_length    = count_in[POS_W-1:0];
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff  <= step_in;
      last_ff  <= last_in;
      tgt_ff   <= tgt_in;
      found_ff <= found_in;
      mode_ff  <= mode_in;
      val_ff   <= val_in;
      rd_ff    <= rd_in;
      rsp_ff   <= rsp_in;
   end

   assign busy      = (state_ff == ST_SCAN);
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CAP_L)
      else $error("list length above capacity");

   a_no_rsp_in_scan: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN |-> !rsp_valid_ff)
      else $error("result strobe during scan");

   a_quick_rsp: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && start &&
       (req.kind == KIND_CLEAR || req.kind == KIND_INSERT ||
        req.kind == KIND_APPEND || req.kind == KIND_DELETE))
      |=> rsp_valid_ff)
      else $error("single-cycle transaction gave no result");

   a_step_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN |-> step_ff <= last_ff)
      else $error("scan ran past list end");

   a_scan_keeps_len: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN && mode_ff != KIND_DELETE_ALL)
      |=> count_ff == $past(count_ff))
      else $error("find or read changed the length");

endmodule

// ===== design/ordered_list_table_engine.sv =====
// Top level of the ordered list table engine: sequencer plus a chain of
// CAPACITY entry cells. Depends on olte_pkg, olte_ctrl and olte_cell.
//
// A transaction is taken when start is high and busy is low; its result is
// shown on rsp for exactly one cycle with rsp_valid, and cannot be held off.
// Clear, insert, append and delete-at-position finish in the accepting cycle:
// the result appears in the next cycle and busy stays low, so one of these can
// be issued every cycle. Find, read (at a valid position) and delete-all
// rotate the list once through the head cell, one entry per cycle: busy is
// high while the list rotates and the result follows in the next cycle,
// when a new transaction may already be accepted. These three finish at
// once on an empty list, as does any operation that fails.
module ordered_list_table_engine
   import olte_pkg::*;
#(
   parameter int CAPACITY = DEFAULT_CAPACITY
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   output logic          busy,
   input  olte_req_type  req,
   output logic          rsp_valid,
   output olte_rsp_type  rsp
);

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int LW    = (CNT_W > POS_W) ? CNT_W : POS_W;

   olte_cell_cmd_type  cell_cmd;
   logic [LW-1:0]      cell_index;
   logic [DATA_W-1:0]  cell_value;
   logic [DATA_W-1:0]  cell_q [CAPACITY];

   olte_ctrl #(
      .CAPACITY (CAPACITY),
      .LW       (LW)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req        (req),
      .rsp_valid  (rsp_valid),
      .rsp        (rsp),
      .head_value (cell_q[0]),
      .cell_cmd   (cell_cmd),
      .cell_index (cell_index),
      .cell_value (cell_value)
   );

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [DATA_W-1:0] left_value, right_value;
      if (i == 0) begin : g_first
         assign left_value = cell_value;
      end else begin : g_mid_l
         assign left_value = cell_q[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign right_value = cell_q[i];
      end else begin : g_mid_r
         assign right_value = cell_q[i+1];
      end
      olte_cell #(
         .LW  (LW),
         .IDX (i)
      ) u_cell (
         .clock       (clock),
         .cmd         (cell_cmd),
         .index       (cell_index),
         .wr_value    (cell_value),
         .left_value  (left_value),
         .right_value (right_value),
         .value       (cell_q[i])
      );
   end

endmodule
